@@ rtl/arta_pkg.sv @@
`timescale 1ns / 1ps
package arta_pkg;

	localparam logic [1:0] OP_MAP   = 2'd0;
	localparam logic [1:0] OP_UNMAP = 2'd1;
	localparam logic [1:0] OP_QUERY = 2'd2;
	localparam logic [1:0] OP_CLEAR = 2'd3;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_RANGE    = 2'd1;
	localparam logic [1:0] ST_MISMATCH = 2'd2;
	localparam logic [1:0] ST_FULL     = 2'd3;

	localparam logic [31:0] LIMIT_RESET = 32'h8000_0000;

	typedef enum logic [9:0] {
		S_IDLE     = 10'b00_0000_0001,
		S_START    = 10'b00_0000_0010,
		S_SCAN_RD  = 10'b00_0000_0100,
		S_SCAN_CMP = 10'b00_0000_1000,
		S_FIN_MAP  = 10'b00_0001_0000,
		S_INS_RD   = 10'b00_0010_0000,
		S_INS_WR   = 10'b00_0100_0000,
		S_REM_RD   = 10'b00_1000_0000,
		S_REM_WR   = 10'b01_0000_0000,
		S_DONE     = 10'b10_0000_0000
	} state_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] result_address;
		logic        found;
	} result_t;

endpackage

@@ rtl/arta_req_if.sv @@
`timescale 1ns / 1ps
interface arta_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  opcode;
	logic [31:0] address;
	logic [31:0] length;

	modport source (output valid, opcode, address, length, input ready);
	modport sink (input valid, opcode, address, length, output ready);
endinterface

@@ rtl/arta_rsp_if.sv @@
`timescale 1ns / 1ps
interface arta_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [31:0] result_address;
	logic        found;
	logic [4:0]  region_total;

	modport source (output valid, status, result_address, found, region_total, input ready);
	modport sink (input valid, status, result_address, found, region_total, output ready);
endinterface

@@ rtl/address_region_table_allocator_core.sv @@
`timescale 1ns / 1ps
// Keeps up to MAX_REGIONS page-aligned regions, sorted by start, in one
// synchronous memory of {start page, end page} entries. Requests are taken
// one at a time; each walks the table one entry at a time, a read state and
// a compare state per entry, through the memory read port, and map and unmap
// then shift entries one at a time, a read and a write each, to insert or
// remove. Clear and a zero-length map skip the walk. A finished result is held
// in an output register, so the next request is taken while it waits.
// address_limit may be written only while idle.
module address_region_table_allocator_core #(
	parameter int MAX_REGIONS = 16,
	parameter int PAGE_SHIFT  = 12
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata,
	arta_req_if.sink    req,
	arta_rsp_if.source  rsp
);

	localparam int PW = 32 - PAGE_SHIFT;
	localparam int IW = $clog2(MAX_REGIONS);
	localparam int CW = $clog2(MAX_REGIONS + 1);
	localparam logic [33:0] PG_MASK = 34'((64'd1 << PAGE_SHIFT) - 64'd1);
	localparam logic [CW-1:0] MAX_CNT = CW'(MAX_REGIONS);

	arta_pkg::state_t state_q;
	logic [31:0]      limit_q;
	logic [CW-1:0]    count_q;
	logic [CW-1:0]    idx_q;
	logic [CW-1:0]    j_q;
	logic [1:0]       op_q;
	logic [31:0]      hint_q;
	logic [32:0]      a_q;
	logic [31:0]      len_q;
	logic [PW-1:0]    end_pg_q;
	arta_pkg::result_t res_q;

	logic [2*PW-1:0]  mem [MAX_REGIONS];
	logic [2*PW-1:0]  rdata_q;
	logic [IW-1:0]    rd_addr;
	logic             mem_we;
	logic [IW-1:0]    mem_wa;
	logic [2*PW-1:0]  mem_wd;

	logic [32:0] sum;
	logic [32:0] ent_start;
	logic [32:0] ent_end;
	logic [33:0] hint_ru;
	logic [33:0] end_ru;
	logic [CW-1:0] j_dec;
	logic [CW-1:0] j_inc;

	// form addresses and sums
	assign sum       = a_q + {1'b0, len_q};
	assign ent_start = 33'({rdata_q[2*PW-1:PW], {PAGE_SHIFT{1'b0}}});
	assign ent_end   = 33'({rdata_q[PW-1:0], {PAGE_SHIFT{1'b0}}});
	assign hint_ru   = ({2'b00, hint_q} + PG_MASK) & ~PG_MASK;
	assign end_ru    = ({1'b0, sum} + PG_MASK) & ~PG_MASK;
	assign j_dec     = j_q - CW'(1);
	assign j_inc     = j_q + CW'(1);

	// select memory read and write addresses
	always_comb begin
		rd_addr = idx_q[IW-1:0];
		mem_we  = 1'b0;
		mem_wa  = j_q[IW-1:0];
		mem_wd  = rdata_q;
		case (state_q)
			arta_pkg::S_INS_RD: begin
				rd_addr = j_dec[IW-1:0];
				if (j_q == idx_q) begin
					mem_we = 1'b1;
					mem_wd = {a_q[31:PAGE_SHIFT], end_pg_q};
				end
			end
			arta_pkg::S_INS_WR: mem_we = 1'b1;
			arta_pkg::S_REM_RD: rd_addr = j_inc[IW-1:0];
			arta_pkg::S_REM_WR: mem_we = 1'b1;
			default: ;
		endcase
	end

	// region memory
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		rdata_q <= mem[rd_addr];
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= arta_pkg::LIMIT_RESET;
		end else if (cfg_we) begin
			limit_q <= cfg_wdata;
		end
	end

	assign req.ready = (state_q == arta_pkg::S_IDLE);

	// request sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q            <= arta_pkg::S_IDLE;
			count_q            <= '0;
			idx_q              <= '0;
			j_q                <= '0;
			rsp.valid          <= 1'b0;
			rsp.status         <= '0;
			rsp.result_address <= '0;
			rsp.found          <= 1'b0;
			rsp.region_total   <= '0;
		end else begin
			// drop the response once taken, unless a new one replaces it
			if (rsp.valid && rsp.ready && state_q != arta_pkg::S_DONE) begin
				rsp.valid <= 1'b0;
			end
			case (state_q)
				arta_pkg::S_IDLE: begin
					if (req.valid) begin
						op_q    <= req.opcode;
						hint_q  <= req.address;
						a_q     <= {1'b0, req.address};
						len_q   <= req.length;
						idx_q   <= '0;
						res_q   <= '{status: arta_pkg::ST_OK, result_address: 32'd0, found: 1'b0};
						state_q <= arta_pkg::S_START;
					end
				end
				arta_pkg::S_START: begin
					case (op_q)
						arta_pkg::OP_MAP: begin
							if (len_q == 32'd0) begin
								res_q.result_address <= hint_q;
								state_q <= arta_pkg::S_DONE;
							end else if (count_q >= MAX_CNT) begin
								res_q.status <= arta_pkg::ST_FULL;
								state_q <= arta_pkg::S_DONE;
							end else begin
								a_q     <= hint_ru[32:0];
								state_q <= arta_pkg::S_SCAN_RD;
							end
						end
						arta_pkg::OP_UNMAP: begin
							if (a_q > {1'b0, limit_q} || sum > {1'b0, limit_q}) begin
								res_q.status <= arta_pkg::ST_RANGE;
								state_q <= arta_pkg::S_DONE;
							end else begin
								state_q <= arta_pkg::S_SCAN_RD;
							end
						end
						arta_pkg::OP_CLEAR: begin
							count_q <= '0;
							state_q <= arta_pkg::S_DONE;
						end
						default: state_q <= arta_pkg::S_SCAN_RD;
					endcase
				end
				arta_pkg::S_SCAN_RD: begin
					if (op_q == arta_pkg::OP_MAP && sum > {1'b0, limit_q}) begin
						res_q.status <= arta_pkg::ST_RANGE;
						state_q <= arta_pkg::S_DONE;
					end else if (idx_q == count_q) begin
						state_q <= (op_q == arta_pkg::OP_MAP) ? arta_pkg::S_FIN_MAP
							: arta_pkg::S_DONE;
					end else begin
						state_q <= arta_pkg::S_SCAN_CMP;
					end
				end
				arta_pkg::S_SCAN_CMP: begin
					// skip entries ending at or below the current address
					if (ent_end <= a_q) begin
						idx_q   <= idx_q + CW'(1);
						state_q <= arta_pkg::S_SCAN_RD;
					end else begin
						case (op_q)
							arta_pkg::OP_MAP: begin
								if (sum <= ent_start) begin
									state_q <= arta_pkg::S_FIN_MAP;
								end else begin
									a_q     <= ent_end;
									idx_q   <= idx_q + CW'(1);
									state_q <= arta_pkg::S_SCAN_RD;
								end
							end
							arta_pkg::OP_UNMAP: begin
								if (ent_start >= sum) begin
									state_q <= arta_pkg::S_DONE;
								end else if (ent_end < sum) begin
									res_q.status <= arta_pkg::ST_MISMATCH;
									state_q <= arta_pkg::S_DONE;
								end else begin
									j_q     <= idx_q;
									state_q <= arta_pkg::S_REM_RD;
								end
							end
							default: begin
								res_q.found <= (ent_start <= a_q);
								state_q <= arta_pkg::S_DONE;
							end
						endcase
					end
				end
				arta_pkg::S_FIN_MAP: begin
					if (end_ru > 34'h0_FFFF_FFFF) begin
						res_q.status <= arta_pkg::ST_RANGE;
						state_q <= arta_pkg::S_DONE;
					end else begin
						end_pg_q <= end_ru[31:PAGE_SHIFT];
						j_q      <= count_q;
						state_q  <= arta_pkg::S_INS_RD;
					end
				end
				arta_pkg::S_INS_RD: begin
					// new entry is written here once the shift reaches its slot
					if (j_q == idx_q) begin
						count_q <= count_q + CW'(1);
						res_q.result_address <= a_q[31:0];
						state_q <= arta_pkg::S_DONE;
					end else begin
						state_q <= arta_pkg::S_INS_WR;
					end
				end
				arta_pkg::S_INS_WR: begin
					j_q     <= j_dec;
					state_q <= arta_pkg::S_INS_RD;
				end
				arta_pkg::S_REM_RD: begin
					if (j_inc >= count_q) begin
						count_q <= count_q - CW'(1);
						res_q.found <= 1'b1;
						state_q <= arta_pkg::S_DONE;
					end else begin
						state_q <= arta_pkg::S_REM_WR;
					end
				end
				arta_pkg::S_REM_WR: begin
					j_q     <= j_inc;
					state_q <= arta_pkg::S_REM_RD;
				end
				arta_pkg::S_DONE: begin
					// hand the result over once the output register is free
					if (!rsp.valid || rsp.ready) begin
						rsp.valid          <= 1'b1;
						rsp.status         <= res_q.status;
						rsp.result_address <= res_q.result_address;
						rsp.found          <= res_q.found;
						rsp.region_total   <= 5'(count_q);
						state_q            <= arta_pkg::S_IDLE;
					end
				end
				default: state_q <= arta_pkg::S_IDLE;
			endcase
		end
	end

endmodule

@@ verif/region_table_scoreboard.sv @@
`timescale 1ns / 1ps
// Predicts the region table and checks each response against the oldest prediction.
class region_table_scoreboard;
	localparam int TABLE_DEPTH = 16;
	localparam int PG_BITS = 12;

	typedef struct {
		logic [1:0]  status;
		logic [31:0] result_address;
		logic        found;
		logic [4:0]  region_total;
	} region_rsp_t;

	logic [32:0] start_pg [TABLE_DEPTH];
	logic [32:0] end_pg [TABLE_DEPTH];
	int unsigned count;
	logic [31:0] limit;
	region_rsp_t pending_rsp [$];
	int errors;

	function new();
		count = 0;
		limit = arta_pkg::LIMIT_RESET;
		errors = 0;
	endfunction

	function logic [32:0] round_pg(logic [32:0] a);
		logic [33:0] s;
		s = {1'b0, a} + ((34'd1 << PG_BITS) - 34'd1);
		s[PG_BITS-1:0] = '0;
		return s[32:0];
	endfunction

	function int unsigned first_end_above(logic [32:0] a);
		int unsigned i;
		for (i = 0; i < count; i++)
			if (end_pg[i] > a) break;
		return i;
	endfunction

	function void push(logic [1:0] st, logic [31:0] ra, logic fd);
		region_rsp_t r;
		r.status = st;
		r.result_address = ra;
		r.found = fd;
		r.region_total = 5'(count);
		pending_rsp.push_back(r);
	endfunction

	function void predict_map(logic [31:0] hint, logic [31:0] len);
		logic [32:0] a, e, lim, l;
		int unsigned i, pos;
		lim = {1'b0, limit};
		l = {1'b0, len};
		if (len == 0) begin
			push(arta_pkg::ST_OK, hint, 1'b0);
			return;
		end
		if (count >= TABLE_DEPTH) begin
			push(arta_pkg::ST_FULL, '0, 1'b0);
			return;
		end
		a = round_pg({1'b0, hint});
		if ({1'b0, a} + l > lim) begin
			push(arta_pkg::ST_RANGE, '0, 1'b0);
			return;
		end
		// walk gaps until one holds the length
		i = first_end_above(a);
		forever begin
			if ({1'b0, a} + l > lim) begin
				push(arta_pkg::ST_RANGE, '0, 1'b0);
				return;
			end
			if (i >= count || {1'b0, a} + l <= start_pg[i]) break;
			a = end_pg[i];
			i++;
		end
		e = round_pg(a + l);
		if (e > 33'hFFFF_FFFF) begin
			push(arta_pkg::ST_RANGE, '0, 1'b0);
			return;
		end
		pos = 0;
		while (pos < count && start_pg[pos] <= a) pos++;
		for (int unsigned k = count; k > pos; k--) begin
			start_pg[k] = start_pg[k-1];
			end_pg[k] = end_pg[k-1];
		end
		start_pg[pos] = a;
		end_pg[pos] = e;
		count++;
		push(arta_pkg::ST_OK, a[31:0], 1'b0);
	endfunction

	function void predict_unmap(logic [31:0] addr, logic [31:0] len);
		logic [32:0] a, fin;
		int unsigned i;
		a = {1'b0, addr};
		fin = a + {1'b0, len};
		if (addr > limit || fin > {1'b0, limit}) begin
			push(arta_pkg::ST_RANGE, '0, 1'b0);
			return;
		end
		i = first_end_above(a);
		if (i >= count || start_pg[i] >= fin) begin
			push(arta_pkg::ST_OK, '0, 1'b0);
			return;
		end
		if (end_pg[i] < fin) begin
			push(arta_pkg::ST_MISMATCH, '0, 1'b0);
			return;
		end
		for (int unsigned j = i; j + 1 < count; j++) begin
			start_pg[j] = start_pg[j+1];
			end_pg[j] = end_pg[j+1];
		end
		count--;
		push(arta_pkg::ST_OK, '0, 1'b1);
	endfunction

	// Note an accepted request and queue the response it should produce.
	function void note_request(logic [1:0] op, logic [31:0] addr, logic [31:0] len);
		int unsigned i;
		case (op)
			arta_pkg::OP_MAP: predict_map(addr, len);
			arta_pkg::OP_UNMAP: predict_unmap(addr, len);
			arta_pkg::OP_QUERY: begin
				i = first_end_above({1'b0, addr});
				push(arta_pkg::ST_OK, '0, (i < count && start_pg[i] <= {1'b0, addr}));
			end
			default: begin
				count = 0;
				push(arta_pkg::ST_OK, '0, 1'b0);
			end
		endcase
	endfunction

	function void check_response(logic [1:0] st, logic [31:0] ra, logic fd, logic [4:0] tot);
		region_rsp_t e;
		if (pending_rsp.size() == 0) begin
			$display("%0t: unexpected response status=%0d addr=%h found=%0d total=%0d",
				$time, st, ra, fd, tot);
			errors++;
			return;
		end
		e = pending_rsp.pop_front();
		if (st !== e.status) begin
			$display("%0t: status expected %0d actual %0d", $time, e.status, st);
			errors++;
		end
		if (ra !== e.result_address) begin
			$display("%0t: result_address expected %h actual %h", $time,
				e.result_address, ra);
			errors++;
		end
		if (fd !== e.found) begin
			$display("%0t: found expected %0d actual %0d", $time, e.found, fd);
			errors++;
		end
		if (tot !== e.region_total) begin
			$display("%0t: region_total expected %0d actual %0d", $time,
				e.region_total, tot);
			errors++;
		end
	endfunction
endclass

@@ verif/testbench.sv @@
`timescale 1ns / 1ps
module testbench;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [31:0] cfg_wdata;
	logic stall_on;

	arta_req_if req ();
	arta_rsp_if rsp ();

	region_table_scoreboard board;

	address_region_table_allocator_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.req(req.sink),
		.rsp(rsp.source)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#40_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	// Note accepted requests and check accepted responses at the rising edge.
	always @(posedge clk) begin
		if (arst_n && req.valid && req.ready)
			board.note_request(req.opcode, req.address, req.length);
		if (arst_n && rsp.valid && rsp.ready)
			board.check_response(rsp.status, rsp.result_address, rsp.found,
				rsp.region_total);
	end

	// Stall the response side in on and off stretches.
	initial begin
		int unsigned run;
		rsp.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (run == 0) begin
				run = $urandom_range(1, 30);
				stall_on = ($urandom_range(0, 2) == 0);
			end
			run--;
			rsp.ready <= stall_on ? ($urandom_range(0, 3) == 0) : 1'b1;
		end
	end

	int unsigned burst_left;

	// Drop the request and scramble its payload.
	task automatic idle_request();
		req.valid <= 1'b0;
		req.opcode <= 2'($urandom());
		req.address <= $urandom();
		req.length <= $urandom();
	endtask

	// Send one request, holding it until accepted; gaps fall between bursts.
	task automatic send_request(logic [1:0] op, logic [31:0] addr, logic [31:0] len);
		int unsigned gap;
		gap = 0;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
		end
		if (gap != 0) begin
			idle_request();
			repeat (gap) @(negedge clk);
		end
		burst_left--;
		req.valid <= 1'b1;
		req.opcode <= op;
		req.address <= addr;
		req.length <= len;
		do @(posedge clk); while (!req.ready);
		@(negedge clk);
	endtask

	// Drain all responses, let the block go idle, then write the limit.
	task automatic write_limit(logic [31:0] value);
		int unsigned guard;
		guard = 0;
		idle_request();
		while (board.pending_rsp.size() != 0 && guard < 100000) begin
			@(negedge clk);
			guard++;
		end
		repeat (120) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		board.limit = value;
	endtask

	function automatic logic [31:0] near_addr(logic [31:0] lim);
		logic [31:0] a;
		case ($urandom_range(0, 3))
			0: a = $urandom();
			1: a = (32'($urandom_range(0, 63)) << 12) + 32'($urandom_range(0, 4095));
			default: a = (32'($urandom_range(0, 48)) << 12) +
				(($urandom_range(0, 3) == 0) ? 32'($urandom_range(0, 4095)) : 32'd0);
		endcase
		if ($urandom_range(0, 9) == 0) a = lim - $urandom_range(0, 8192);
		return a;
	endfunction

	function automatic logic [31:0] pick_len();
		case ($urandom_range(0, 9))
			0: return 32'd0;
			1: return $urandom();
			2: return 32'hFFFF_FFFF;
			default: return $urandom_range(1, 5 * 4096);
		endcase
	endfunction

	// Run random requests, mostly maps and unmaps on a small address window.
	task automatic random_phase(int unsigned n, logic [31:0] lim);
		logic [1:0] op;
		int unsigned r;
		for (int unsigned k = 0; k < n; k++) begin
			r = $urandom_range(0, 99);
			if (r < 45) op = arta_pkg::OP_MAP;
			else if (r < 75) op = arta_pkg::OP_UNMAP;
			else if (r < 97) op = arta_pkg::OP_QUERY;
			else op = arta_pkg::OP_CLEAR;
			send_request(op, near_addr(lim), pick_len());
		end
	endtask

	initial begin
		int unsigned waited;
		board = new();
		burst_left = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		req.valid = 1'b0;
		req.opcode = arta_pkg::OP_MAP;
		req.address = '0;
		req.length = '0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: extremes, every operation and the named corner cases.
		send_request(arta_pkg::OP_MAP, 32'h0, 32'h0);
		send_request(arta_pkg::OP_MAP, 32'hFFFF_FFFF, 32'h0);
		send_request(arta_pkg::OP_MAP, 32'h0, 32'h1);
		send_request(arta_pkg::OP_MAP, 32'h0, 32'h1000);
		send_request(arta_pkg::OP_MAP, 32'h3001, 32'h2000);
		send_request(arta_pkg::OP_MAP, 32'hFFFF_FFFF, 32'h1);
		send_request(arta_pkg::OP_MAP, 32'h0, 32'hFFFF_FFFF);
		send_request(arta_pkg::OP_MAP, 32'h7FFF_F000, 32'h1000);
		send_request(arta_pkg::OP_QUERY, 32'h0, 32'h0);
		send_request(arta_pkg::OP_QUERY, 32'h4FFF, 32'h0);
		send_request(arta_pkg::OP_QUERY, 32'hFFFF_FFFF, 32'h0);
		send_request(arta_pkg::OP_UNMAP, 32'h8000_0001, 32'h0);
		send_request(arta_pkg::OP_UNMAP, 32'h10, 32'hFFFF_FFFF);
		send_request(arta_pkg::OP_UNMAP, 32'h2_0000, 32'h10);
		send_request(arta_pkg::OP_UNMAP, 32'h4000, 32'h8000);
		send_request(arta_pkg::OP_UNMAP, 32'h10, 32'h0);
		send_request(arta_pkg::OP_UNMAP, 32'h4000, 32'h1000);
		for (int k = 0; k < 17; k++) send_request(arta_pkg::OP_MAP, 32'h0, 32'h800);
		send_request(arta_pkg::OP_MAP, 32'h0, 32'h0);
		send_request(arta_pkg::OP_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

		random_phase(300, 32'h8000_0000);
		// Unaligned top limit: rounded end can reach 2^32.
		write_limit(32'hFFFF_FFFF);
		send_request(arta_pkg::OP_MAP, 32'hFFFF_E000, 32'h1FFF);
		send_request(arta_pkg::OP_MAP, 32'hFFFF_F000, 32'hFFF);
		random_phase(300, 32'hFFFF_FFFF);
		write_limit(32'h0);
		random_phase(80, 32'h0);
		write_limit(32'h0003_0800);
		random_phase(250, 32'h0003_0800);
		write_limit(32'h0001_0000);
		random_phase(300, 32'h0001_0000);
		idle_request();

		waited = 0;
		while (board.pending_rsp.size() != 0 && waited < 200000) begin
			@(negedge clk);
			waited++;
		end
		repeat (200) @(negedge clk);
		if (board.errors == 0 && board.pending_rsp.size() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end
endmodule

@@ files.f @@
rtl/arta_pkg.sv
rtl/arta_req_if.sv
rtl/arta_rsp_if.sv
rtl/address_region_table_allocator_core.sv
verif/region_table_scoreboard.sv
verif/testbench.sv
